[hdl/pfcm_pkg.sv]
// shared types, constants and root table of the pfcm membership block
`default_nettype none

package pfcm_pkg;

	localparam int CLASSES_DEF  = 4;
	localparam int CHANNELS_DEF = 2;

	localparam int OP_W    = 2;
	localparam int CLS_W   = 2;
	localparam int CH_W    = 1;
	localparam int VAL_W   = 24;
	localparam int Q_W     = 17;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int DIV_W   = 50;
	localparam int LOG_W   = 22;
	localparam int POW_W   = 48;

	localparam logic [OP_W-1:0] OP_CENTER = 2'd0;
	localparam logic [OP_W-1:0] OP_ETA    = 2'd1;
	localparam logic [OP_W-1:0] OP_PIXEL  = 2'd2;

	localparam logic [1:0] REG_FCM_EXP = 2'd0;
	localparam logic [1:0] REG_PCM_EXP = 2'd1;
	localparam logic [1:0] REG_WEIGHT  = 2'd2;
	localparam logic [1:0] REG_CLOSE   = 2'd3;

	localparam logic [15:0] FCM_EXP_RST = 16'd8192;
	localparam logic [15:0] PCM_EXP_RST = 16'd8192;
	localparam logic [15:0] WEIGHT_RST  = 16'd256;
	localparam logic [31:0] CLOSE_RST   = 32'd256;

	localparam logic [Q_W-1:0]   ONE_Q16 = 17'h10000;
	localparam logic [POW_W-1:0] SAT_Q16 = 48'h8000_0000_0000;

	typedef struct packed {
		logic [15:0] fcm_exponent;
		logic [15:0] pcm_exponent;
		logic [15:0] pcm_weight;
		logic [31:0] closeness_limit;
	} cfg_t;

	typedef logic [16:0][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic root_tab_t calc_roots();
		root_tab_t t;
		t[0] = 32'h8000_0000;
		for (int k = 1; k <= 16; k++) begin
			t[k] = 32'(isqrt64({32'b0, t[k-1]} << 30));
		end
		return t;
	endfunction

	// r_k = 2^(2^-k) in Q.30
	localparam root_tab_t ROOT_TAB = calc_roots();

endpackage

`default_nettype wire

[hdl/pfcm_if.sv]
// item and result channel interfaces of the pfcm membership block
`default_nettype none

interface pfcm_item_if
	import pfcm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [CLS_W-1:0] class_index;
	logic [CH_W-1:0]  channel_index;
	logic [VAL_W-1:0] load_value;
	logic [VAL_W-1:0] feature_first;
	logic [VAL_W-1:0] feature_second;

	modport source(output valid, op, class_index, channel_index, load_value,
		feature_first, feature_second, input ready);
	modport sink(input valid, op, class_index, channel_index, load_value,
		feature_first, feature_second, output ready);
endinterface

interface pfcm_result_if
	import pfcm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CLS_W-1:0] result_class;
	logic [Q_W-1:0]   membership;
	logic [Q_W-1:0]   typicality;
	logic             last_class;

	modport source(output valid, result_class, membership, typicality, last_class,
		input ready);
	modport sink(input valid, result_class, membership, typicality, last_class,
		output ready);
endinterface

`default_nettype wire

[hdl/pfcm_cfg.sv]
// apb configuration registers of the pfcm membership block
`default_nettype none

module pfcm_cfg
	import pfcm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr;
	logic [1:0] idx;

	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fcm_exponent    <= FCM_EXP_RST;
			cfg_q.pcm_exponent    <= PCM_EXP_RST;
			cfg_q.pcm_weight      <= WEIGHT_RST;
			cfg_q.closeness_limit <= CLOSE_RST;
		end else if (wr) begin
			unique case (idx)
				REG_FCM_EXP: cfg_q.fcm_exponent    <= pwdata[15:0];
				REG_PCM_EXP: cfg_q.pcm_exponent    <= pwdata[15:0];
				REG_WEIGHT:  cfg_q.pcm_weight      <= pwdata[15:0];
				REG_CLOSE:   cfg_q.closeness_limit <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FCM_EXP: prdata = {16'b0, cfg_q.fcm_exponent};
			REG_PCM_EXP: prdata = {16'b0, cfg_q.pcm_exponent};
			REG_WEIGHT:  prdata = {16'b0, cfg_q.pcm_weight};
			REG_CLOSE:   prdata = cfg_q.closeness_limit;
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[hdl/pfcm_mul.sv]
// shared 32x32 multiplier with registered product
`default_nettype none

module pfcm_mul
	import pfcm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

`default_nettype wire

[hdl/pfcm_div.sv]
// shared bit-serial restoring divider
`default_nettype none

module pfcm_div
	import pfcm_pkg::*;
#(
	parameter int W = DIV_W
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic      [W-1:0] quo
);

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W:0]       rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [W:0]       rem_sh;
	logic             fits;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
				quo_q <= {quo_q[W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

[hdl/pfcm_membership_typicality.sv]
// top level: pfcm membership and typicality sequencer
//
// item channel (valid/ready): op 0 writes a center component, op 1 a class eta,
// op 2 classifies a pixel from feature_first and feature_second
// result channel (valid/ready): one transfer per class in class order for each
// pixel, last_class marks the final one; writes give no result
// apb port: fcm_exponent, pcm_exponent, pcm_weight, closeness_limit at 0,4,8,12
// writes take effect in the access phase and ready stays high
// a pixel runs distance and log2 for each class, then for each class
// one power term per class, the membership quotient and, where pcm_weight
// and eta are nonzero, a log2, power term and quotient for typicality
// the bit-serial divider and the shared 32x32 multiplier do this work
// a pixel that snaps to a class finishes after the distance pass, one cycle
// per result while result ready stays high
// ready is low while a pixel is in work; a stalled result holds the sequencer
// at the next result until taken
// reset clears control and restores register defaults; stores are undefined
// until written
`default_nettype none

module pfcm_membership_typicality
	import pfcm_pkg::*;
#(
	parameter int CLASSES  = CLASSES_DEF,
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	pfcm_item_if.sink              item,
	pfcm_result_if.source          result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	localparam int CW = $clog2(CLASSES);
	localparam int CD = CLASSES * CHANNELS;
	localparam int IW = (CD > 1) ? $clog2(CD) : 1;
	localparam logic [CW-1:0]  LAST_CLS = CW'(CLASSES - 1);
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DMUL   = 5'd1;
	localparam logic [4:0] S_DACC   = 5'd2;
	localparam logic [4:0] S_LNORM  = 5'd3;
	localparam logic [4:0] S_LSQ    = 5'd4;
	localparam logic [4:0] S_LACC   = 5'd5;
	localparam logic [4:0] S_LRET   = 5'd6;
	localparam logic [4:0] S_ROW    = 5'd7;
	localparam logic [4:0] S_TERM   = 5'd8;
	localparam logic [4:0] S_PDIV   = 5'd9;
	localparam logic [4:0] S_PDWAIT = 5'd10;
	localparam logic [4:0] S_PFRAC  = 5'd11;
	localparam logic [4:0] S_PFACC  = 5'd12;
	localparam logic [4:0] S_PFIN   = 5'd13;
	localparam logic [4:0] S_PRET   = 5'd14;
	localparam logic [4:0] S_USTART = 5'd15;
	localparam logic [4:0] S_UWAIT  = 5'd16;
	localparam logic [4:0] S_TSTART = 5'd17;
	localparam logic [4:0] S_TWAIT  = 5'd18;
	localparam logic [4:0] S_EMIT   = 5'd19;

	localparam logic [1:0] LRET_DIST = 2'd0;
	localparam logic [1:0] LRET_W    = 2'd1;
	localparam logic [1:0] LRET_ETA  = 2'd2;
	localparam logic       PRET_TERM = 1'b0;
	localparam logic       PRET_PT   = 1'b1;

	localparam logic [DIV_W-1:0] TWO32 = DIV_W'(64'h1_0000_0000);

	cfg_t cfg;

	logic [VAL_W-1:0] center_q [CD];
	logic [VAL_W-1:0] eta_q [CLASSES];
	logic [LOG_W-1:0] lg_q [CLASSES];

	logic [4:0]       state_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    i_q;
	logic [CH_W-1:0]  c_q;
	logic             snap_q;
	logic [CW-1:0]    snap_idx_q;
	logic [VAL_W-1:0] feat0_q;
	logic [VAL_W-1:0] feat1_q;
	logic [49:0]      acc_q;
	logic [49:0]      lx_q;
	logic [5:0]       lp_q;
	logic [2:0]       lstep_q;
	logic [31:0]      lm_q;
	logic [15:0]      lfrac_q;
	logic [3:0]       lit_q;
	logic [1:0]       lret_q;
	logic [LOG_W-1:0] lw_q;
	logic [LOG_W-1:0] lg_i_q;
	logic             pneg_q;
	logic [23:0]      pmag_q;
	logic [15:0]      pden_q;
	logic             pret_q;
	logic [4:0]       pn_q;
	logic [15:0]      pf_q;
	logic [4:0]       pk_q;
	logic [31:0]      mant_q;
	logic [POW_W-1:0] pow_q;
	logic [DIV_W-1:0] s_q;
	logic [Q_W-1:0]   u_q;
	logic [Q_W-1:0]   t_q;
	logic             rv_q;
	logic [CLS_W-1:0] rcls_q;
	logic [Q_W-1:0]   rmem_q;
	logic [Q_W-1:0]   rtyp_q;
	logic             rlast_q;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       prod;
	logic              div_start;
	logic [DIV_W-1:0]  div_num;
	logic [DIV_W-1:0]  div_den;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;

	logic [VAL_W-1:0] fa;
	logic [VAL_W-1:0] cb;
	logic [VAL_W-1:0] df;
	logic [49:0]      acc_n;
	logic [39:0]      lim;
	logic [15:0]      denf;
	logic [15:0]      denp;
	logic [5:0]       stride;
	logic             ltop_zero;
	logic [49:0]      lnx;
	logic [5:0]       lpn;
	logic [32:0]      m2;
	logic [LOG_W-1:0] lres;
	logic [CW-1:0]    lg_addr;
	logic [LOG_W-1:0] lg_rd;
	logic signed [23:0] term_l;
	logic signed [23:0] eta_l;
	logic [23:0]      term_abs;
	logic [23:0]      eta_abs;
	logic             e_big;
	logic [4:0]       e_n;
	logic [15:0]      e_f;
	logic [61:0]      sh_up;
	logic [POW_W-1:0] pos_val;
	logic [POW_W-1:0] neg_val;
	logic [DIV_W-1:0] q_t;
	logic [IW-1:0]    rd_idx;
	logic [IW-1:0]    wr_idx;
	logic             emit_go;
	logic             in_go;
	logic             is_snap_cls;

	pfcm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfcm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	pfcm_div #(.W(DIV_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign item.ready = (state_q == S_IDLE);
	assign in_go      = item.valid & item.ready;
	assign emit_go    = (state_q == S_EMIT) & (~rv_q | result.ready);

	assign result.valid        = rv_q;
	assign result.result_class = rcls_q;
	assign result.membership   = rmem_q;
	assign result.typicality   = rtyp_q;
	assign result.last_class   = rlast_q;

	// distance datapath
	assign rd_idx = IW'(int'(k_q) * CHANNELS + int'(c_q));
	assign wr_idx = IW'(int'(item.class_index) * CHANNELS + int'(item.channel_index));
	assign fa     = (c_q == '0) ? feat0_q : feat1_q;
	assign cb     = center_q[rd_idx];
	assign df     = (fa > cb) ? fa - cb : cb - fa;
	assign acc_n  = acc_q + prod[49:0];
	assign lim    = {((cfg.closeness_limit == '0) ? 32'd1 : cfg.closeness_limit), 8'b0};
	assign denf   = ((cfg.fcm_exponent > 16'd4096) ? cfg.fcm_exponent : 16'd4097) - 16'd4096;
	assign denp   = ((cfg.pcm_exponent > 16'd4096) ? cfg.pcm_exponent : 16'd4097) - 16'd4096;

	// log2 datapath
	assign stride    = 6'd32 >> lstep_q;
	assign ltop_zero = (lx_q >> (6'd50 - stride)) == '0;
	assign lnx       = ltop_zero ? (lx_q << stride) : lx_q;
	assign lpn       = ltop_zero ? (lp_q - stride) : lp_q;
	assign m2        = prod[63:31];
	assign lres      = {lp_q, lfrac_q};

	assign lg_addr = (state_q == S_ROW) ? i_q : k_q;
	assign lg_rd   = lg_q[lg_addr];
	assign term_l  = $signed({2'b0, lg_i_q}) - $signed({2'b0, lg_rd});
	assign eta_l   = $signed({2'b0, lg_i_q}) + $signed({2'b0, lw_q})
		- $signed({2'b0, lres}) - 24'sd1048576;
	assign term_abs = term_l[23] ? 24'(-term_l) : 24'(term_l);
	assign eta_abs  = eta_l[23] ? 24'(-eta_l) : 24'(eta_l);

	// power datapath
	assign e_big   = (div_quo[49:21] != '0) || (div_quo[20:16] == 5'd31);
	assign e_n     = div_quo[20:16];
	assign e_f     = div_quo[15:0];
	assign sh_up   = {30'b0, mant_q} << pn_q;
	assign pos_val = (sh_up[61:14] > SAT_Q16) ? SAT_Q16 : sh_up[61:14];
	assign neg_val = POW_W'({16'b0, mant_q} >> (6'd14 + {1'b0, pn_q}));
	assign q_t     = DIV_W'(pow_q) + DIV_W'(ONE_Q16);

	assign is_snap_cls = (i_q == snap_idx_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_DMUL: begin
				mul_a = {8'b0, df};
				mul_b = {8'b0, df};
			end
			S_LSQ: begin
				mul_a = lm_q;
				mul_b = lm_q;
			end
			S_PFRAC: begin
				mul_a = mant_q;
				mul_b = ROOT_TAB[pk_q];
			end
			default: ;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			S_PDIV: begin
				div_start = 1'b1;
				div_num   = DIV_W'({pmag_q, 12'b0});
				div_den   = DIV_W'(pden_q);
			end
			S_USTART: begin
				div_start = 1'b1;
				div_num   = TWO32 + (s_q >> 1);
				div_den   = s_q;
			end
			S_TSTART: begin
				div_start = 1'b1;
				div_num   = TWO32 + (q_t >> 1);
				div_den   = q_t;
			end
			default: ;
		endcase
	end

	// stores
	always_ff @(posedge clk) begin
		if (in_go && item.op == OP_CENTER && int'(item.class_index) < CLASSES
				&& int'(item.channel_index) < CHANNELS) begin
			center_q[wr_idx] <= item.load_value;
		end
		if (in_go && item.op == OP_ETA && int'(item.class_index) < CLASSES) begin
			eta_q[CW'(item.class_index)] <= item.load_value;
		end
		if (state_q == S_LRET && lret_q == LRET_DIST) begin
			lg_q[k_q] <= lres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			k_q        <= '0;
			i_q        <= '0;
			c_q        <= '0;
			snap_q     <= 1'b0;
			snap_idx_q <= '0;
			feat0_q    <= '0;
			feat1_q    <= '0;
			acc_q      <= '0;
			lx_q       <= '0;
			lp_q       <= '0;
			lstep_q    <= '0;
			lm_q       <= '0;
			lfrac_q    <= '0;
			lit_q      <= '0;
			lret_q     <= LRET_DIST;
			lw_q       <= '0;
			lg_i_q     <= '0;
			pneg_q     <= 1'b0;
			pmag_q     <= '0;
			pden_q     <= '0;
			pret_q     <= PRET_TERM;
			pn_q       <= '0;
			pf_q       <= '0;
			pk_q       <= '0;
			mant_q     <= '0;
			pow_q      <= '0;
			s_q        <= '0;
			u_q        <= '0;
			t_q        <= '0;
			rv_q       <= 1'b0;
			rcls_q     <= '0;
			rmem_q     <= '0;
			rtyp_q     <= '0;
			rlast_q    <= 1'b0;
		end else begin
			if (emit_go) begin
				rv_q    <= 1'b1;
				rcls_q  <= CLS_W'(i_q);
				rlast_q <= (i_q == LAST_CLS);
				if (snap_q) begin
					rmem_q <= is_snap_cls ? ONE_Q16 : '0;
					rtyp_q <= is_snap_cls ? ONE_Q16 : '0;
				end else begin
					rmem_q <= u_q;
					rtyp_q <= t_q;
				end
			end else if (result.ready) begin
				rv_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_go && item.op == OP_PIXEL) begin
						feat0_q <= item.feature_first;
						feat1_q <= item.feature_second;
						acc_q   <= '0;
						k_q     <= '0;
						c_q     <= '0;
						snap_q  <= 1'b0;
						state_q <= S_DMUL;
					end
				end
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					if (c_q == LAST_CH) begin
						if (!snap_q && acc_n < 50'(lim)) begin
							snap_q     <= 1'b1;
							snap_idx_q <= k_q;
						end
						lx_q    <= acc_n;
						lp_q    <= 6'd49;
						lstep_q <= '0;
						lret_q  <= LRET_DIST;
						state_q <= S_LNORM;
					end else begin
						acc_q   <= acc_n;
						c_q     <= c_q + 1'b1;
						state_q <= S_DMUL;
					end
				end
				S_LNORM: begin
					lx_q    <= lnx;
					lp_q    <= lpn;
					lstep_q <= lstep_q + 1'b1;
					if (lstep_q == 3'd5) begin
						lm_q    <= lnx[49:18];
						lfrac_q <= '0;
						lit_q   <= '0;
						state_q <= S_LSQ;
					end
				end
				S_LSQ: state_q <= S_LACC;
				S_LACC: begin
					lfrac_q <= {lfrac_q[14:0], m2[32]};
					lm_q    <= m2[32] ? m2[32:1] : m2[31:0];
					lit_q   <= lit_q + 1'b1;
					state_q <= (lit_q == 4'd15) ? S_LRET : S_LSQ;
				end
				S_LRET: begin
					unique case (lret_q)
						LRET_DIST: begin
							acc_q <= '0;
							c_q   <= '0;
							if (k_q == LAST_CLS) begin
								i_q <= '0;
								if (snap_q) begin
									state_q <= S_EMIT;
								end else if (cfg.pcm_weight != '0) begin
									lx_q    <= 50'(cfg.pcm_weight);
									lp_q    <= 6'd49;
									lstep_q <= '0;
									lret_q  <= LRET_W;
									state_q <= S_LNORM;
								end else begin
									state_q <= S_ROW;
								end
							end else begin
								k_q     <= k_q + 1'b1;
								state_q <= S_DMUL;
							end
						end
						LRET_W: begin
							lw_q    <= lres;
							state_q <= S_ROW;
						end
						LRET_ETA: begin
							pneg_q  <= eta_l[23];
							pmag_q  <= eta_abs;
							pden_q  <= denp;
							pret_q  <= PRET_PT;
							state_q <= S_PDIV;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_ROW: begin
					lg_i_q  <= lg_rd;
					s_q     <= '0;
					k_q     <= '0;
					state_q <= S_TERM;
				end
				S_TERM: begin
					pneg_q  <= term_l[23];
					pmag_q  <= term_abs;
					pden_q  <= denf;
					pret_q  <= PRET_TERM;
					state_q <= S_PDIV;
				end
				S_PDIV: state_q <= S_PDWAIT;
				S_PDWAIT: begin
					if (div_done) begin
						if (e_big) begin
							pow_q   <= pneg_q ? '0 : SAT_Q16;
							state_q <= S_PRET;
						end else begin
							if (pneg_q && e_f != '0) begin
								pf_q <= 16'(17'h10000 - {1'b0, e_f});
								pn_q <= e_n + 1'b1;
							end else begin
								pf_q <= e_f;
								pn_q <= e_n;
							end
							mant_q  <= 32'h4000_0000;
							pk_q    <= 5'd1;
							state_q <= S_PFRAC;
						end
					end
				end
				S_PFRAC: begin
					if (pf_q[4'(5'd16 - pk_q)]) begin
						state_q <= S_PFACC;
					end else if (pk_q == 5'd16) begin
						state_q <= S_PFIN;
					end else begin
						pk_q <= pk_q + 1'b1;
					end
				end
				S_PFACC: begin
					mant_q <= prod[61:30];
					if (pk_q == 5'd16) begin
						state_q <= S_PFIN;
					end else begin
						pk_q    <= pk_q + 1'b1;
						state_q <= S_PFRAC;
					end
				end
				S_PFIN: begin
					pow_q   <= pneg_q ? neg_val : pos_val;
					state_q <= S_PRET;
				end
				S_PRET: begin
					if (pret_q == PRET_TERM) begin
						s_q <= s_q + DIV_W'(pow_q);
						if (k_q == LAST_CLS) begin
							state_q <= S_USTART;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_TERM;
						end
					end else begin
						state_q <= S_TSTART;
					end
				end
				S_USTART: state_q <= S_UWAIT;
				S_UWAIT: begin
					if (div_done) begin
						u_q <= div_quo[Q_W-1:0];
						if (cfg.pcm_weight == '0) begin
							t_q     <= ONE_Q16;
							state_q <= S_EMIT;
						end else if (eta_q[i_q] == '0) begin
							t_q     <= '0;
							state_q <= S_EMIT;
						end else begin
							lx_q    <= 50'(eta_q[i_q]);
							lp_q    <= 6'd49;
							lstep_q <= '0;
							lret_q  <= LRET_ETA;
							state_q <= S_LNORM;
						end
					end
				end
				S_TSTART: state_q <= S_TWAIT;
				S_TWAIT: begin
					if (div_done) begin
						t_q     <= div_quo[Q_W-1:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						if (i_q == LAST_CLS) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= snap_q ? S_EMIT : S_ROW;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/pfcm_checker.sv]
// port-level assertions of the pfcm membership block and their bind
`default_nettype none

module pfcm_checker
	import pfcm_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_ready,
	input wire logic [OP_W-1:0]  item_op,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire logic [Q_W-1:0]   res_membership,
	input wire logic [Q_W-1:0]   res_typicality
);

	// a pixel keeps the block busy
	ap_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_op == OP_PIXEL |=> !item_ready)
		else $error("ready after pixel transfer");

	// a store write or unused op leaves the block ready
	ap_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_op != OP_PIXEL |=> item_ready)
		else $error("block busy after write");

	ap_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_membership <= 17'h10000 && res_typicality <= 17'h10000)
		else $error("result above one");

	ap_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_membership))
		else $error("stalled result dropped");

endmodule

bind pfcm_membership_typicality pfcm_checker u_pfcm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_op        (item.op),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_membership (result.membership),
	.res_typicality (result.typicality)
);

`default_nettype wire
